### hw/rtl/fall_and_vitals_alert_monitor_assert.svh
// assertion macros for the fall and vitals alert monitor
// no dependencies; included by the file that carries assertions
`ifndef FALL_AND_VITALS_ALERT_MONITOR_ASSERT_SVH
`define FALL_AND_VITALS_ALERT_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define FVA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fva assertion failed");
// consequent must hold in the cycle after the antecedent
`define FVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fva assertion failed");
`else
`define FVA_ASSERT_NOW(label, clk, rst, ante, cons)
`define FVA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/fva_pkg.sv
// shared constants, codes and controller/datapath interface types
// no dependencies
package fva_pkg;

   localparam int RING_DEPTH    = 15;
   localparam int TIMER_BITS    = 24;
   localparam int MAG_BITS      = 16;
   localparam int AXIS_BITS     = 16;
   localparam int SQ_BITS       = 32;
   localparam int REM_BITS      = MAG_BITS + 1;
   localparam int RING_IDX_BITS = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_BITS      = MAG_BITS + RING_IDX_BITS;
   localparam int TICK_REG_BITS = 24;
   localparam int CMP_BITS      = (TIMER_BITS > TICK_REG_BITS) ? TIMER_BITS : TICK_REG_BITS;

   // mean = sum / RING_DEPTH as a multiply by a rounded-up reciprocal
   localparam int RECIP_SHIFT = SUM_BITS + RING_IDX_BITS;
   localparam longint unsigned RECIP_VALUE =
      ((64'd1 << RECIP_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
   localparam int RECIP_BITS  = RECIP_SHIFT - RING_IDX_BITS + 2;
   localparam int MPROD_BITS  = SUM_BITS + RECIP_BITS;

   localparam int SQUARE_STEPS = 4;
   localparam int ROOT_STEPS   = MAG_BITS;
   localparam int STEP_BITS    = $clog2(ROOT_STEPS);

   localparam int REQ_DATA_BITS  = 64;
   localparam int RSP_DATA_BITS  = 40;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [15:0] RST_FALL_LEVEL     = 16'd6683;
   localparam logic [15:0] RST_DROP_LEVEL     = 16'd835;
   localparam logic [7:0]  RST_PULSE_LOW      = 8'd40;
   localparam logic [7:0]  RST_PULSE_HIGH     = 8'd130;
   localparam logic [6:0]  RST_OXYGEN_LOW     = 7'd90;
   localparam logic [23:0] RST_COOLDOWN_TICKS = 24'd10000;
   localparam logic [23:0] RST_HOLD_TICKS     = 24'd3000;
   localparam logic [23:0] RST_AVERAGE_PERIOD = 24'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FALL_LEVEL     = 3'd0,
      CSR_DROP_LEVEL     = 3'd1,
      CSR_PULSE_LOW      = 3'd2,
      CSR_PULSE_HIGH     = 3'd3,
      CSR_OXYGEN_LOW     = 3'd4,
      CSR_COOLDOWN_TICKS = 3'd5,
      CSR_HOLD_TICKS     = 3'd6,
      CSR_AVERAGE_PERIOD = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ALERT_NIL    = 3'd0,
      ALERT_BUTTON = 3'd1,
      ALERT_FALL   = 3'd2,
      ALERT_PULSE  = 3'd3,
      ALERT_OXYGEN = 3'd4
   } alert_kind_type;

   typedef struct packed {
      logic load;
      logic square;
      logic root_step;
      logic decide;
      logic mean_mul;
      logic mean_div;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic avg_pending;
   } dp_status_type;

endpackage

### hw/rtl/fva_ctrl.sv
// sequencing state machine: issues datapath commands per request
// depends on fva_pkg
module fva_ctrl
   import fva_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_DECIDE,
      ST_MEAN_MUL,
      ST_MEAN_DIV,
      ST_FINISH
   } ctrl_state_type;

   ctrl_state_type         state_ff;
   logic [STEP_BITS-1:0]   step_ff;
   logic                   rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_tvalid;
      cmd.square    = (state_ff == ST_SQUARE);
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.decide    = (state_ff == ST_DECIDE);
      cmd.mean_mul  = (state_ff == ST_MEAN_MUL);
      cmd.mean_div  = (state_ff == ST_MEAN_DIV);
      cmd.out_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (req_tvalid) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               if (step_ff == STEP_BITS'(SQUARE_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_ROOT: begin
               if (step_ff == STEP_BITS'(ROOT_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= ST_DECIDE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DECIDE: begin
               state_ff <= ST_MEAN_MUL;
            end
            ST_MEAN_MUL: begin
               state_ff <= status.avg_pending ? ST_MEAN_DIV : ST_FINISH;
            end
            ST_MEAN_DIV: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/fva_dpath.sv
// datapath: squares, bit-serial root, alert decision, ring and mean, result register
// depends on fva_pkg
module fva_dpath
   import fva_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic [REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   output logic [RSP_DATA_BITS-1:0]   rsp_tdata
);

   // configuration
   logic [15:0]              fall_level_ff, drop_level_ff;
   logic [7:0]               pulse_low_ff, pulse_high_ff;
   logic [6:0]               oxygen_low_ff;
   logic [TICK_REG_BITS-1:0] cooldown_ff, hold_ff, period_ff;

   // per-request operands
   logic                     button_ff;
   logic [7:0]               heart_ff;
   logic [6:0]               spo_ff;
   logic [AXIS_BITS-1:0]     abs0_ff, abs1_ff, abs2_ff;
   logic [SQ_BITS-1:0]       prod_ff, acc_ff;
   logic [REM_BITS-1:0]      rem_ff, rem_in;
   logic [MAG_BITS-1:0]      root_ff, root_in;
   logic [MPROD_BITS-1:0]    mprod_ff;

   // persistent state
   logic [MAG_BITS-1:0]      ring_ff [RING_DEPTH];
   logic [SUM_BITS-1:0]      sum_ff;
   logic [RING_IDX_BITS-1:0] pos_ff;
   logic [MAG_BITS-1:0]      mean_ff;
   alert_kind_type           alert_ff;
   logic [TIMER_BITS-1:0]    t_alarm_ff, t_alert_ff, t_avg_ff;
   logic                     avg_pending_ff;

   // tick result flags
   logic                     raised_ff, dropped_ff, released_ff;
   alert_kind_type           kind_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   function automatic logic [AXIS_BITS-1:0] axis_abs(input logic [AXIS_BITS-1:0] raw);
      return raw[AXIS_BITS-1] ? (~raw + 1'b1) : raw;
   endfunction

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
      return (t == {TIMER_BITS{1'b1}}) ? t : t + 1'b1;
   endfunction

   function automatic logic past_limit(input logic [TIMER_BITS-1:0] t,
                                       input logic [TICK_REG_BITS-1:0] lim);
      return CMP_BITS'(t) > CMP_BITS'(lim);
   endfunction

   // one root digit per step, two radicand bits consumed from the top of acc
   logic [REM_BITS+1:0] rem_shift;
   logic [REM_BITS+1:0] trial;

   always_comb begin
      rem_shift = {rem_ff, acc_ff[SQ_BITS-1 -: 2]};
      trial     = (REM_BITS + 2)'({root_ff, 2'b01});
      if (rem_shift >= trial) begin
         rem_in  = REM_BITS'(rem_shift - trial);
         root_in = {root_ff[MAG_BITS-2:0], 1'b1};
      end else begin
         rem_in  = REM_BITS'(rem_shift);
         root_in = {root_ff[MAG_BITS-2:0], 1'b0};
      end
   end

   // alert decision for this tick
   logic [TIMER_BITS-1:0] t_alarm_inc, t_alert_inc, t_avg_inc;
   logic                  release_now, fall_now, raise_now, drop_now, avg_now;
   alert_kind_type        alert_mid, kind_now, alert_new;
   logic [MAG_BITS-1:0]   ring_rd;
   logic [SUM_BITS-1:0]   sum_upd;

   always_comb begin
      t_alarm_inc = sat_inc(t_alarm_ff);
      t_alert_inc = sat_inc(t_alert_ff);
      t_avg_inc   = sat_inc(t_avg_ff);
      release_now = (alert_ff != ALERT_NIL) && past_limit(t_alarm_inc, hold_ff);
      alert_mid   = release_now ? ALERT_NIL : alert_ff;
      fall_now    = (mean_ff > fall_level_ff) && (mean_ff > root_ff) &&
                    ((mean_ff - root_ff) > drop_level_ff);
      kind_now    = ALERT_NIL;
      if (alert_mid == ALERT_NIL) begin
         if (fall_now) begin
            kind_now = ALERT_FALL;
         end else if (button_ff) begin
            kind_now = ALERT_BUTTON;
         end else if ((heart_ff != 8'd0) &&
                      ((heart_ff < pulse_low_ff) || (heart_ff > pulse_high_ff))) begin
            kind_now = ALERT_PULSE;
         end else if ((heart_ff != 8'd0) && (spo_ff != 7'd0) &&
                      (spo_ff < oxygen_low_ff)) begin
            kind_now = ALERT_OXYGEN;
         end
      end
      raise_now = (kind_now != ALERT_NIL) && past_limit(t_alert_inc, cooldown_ff);
      drop_now  = (kind_now != ALERT_NIL) && !raise_now;
      alert_new = raise_now ? kind_now : alert_mid;
      avg_now   = (alert_new == ALERT_NIL) && past_limit(t_avg_inc, period_ff);
      ring_rd   = ring_ff[pos_ff];
      sum_upd   = sum_ff - SUM_BITS'(ring_rd) + SUM_BITS'(root_ff);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fall_level_ff <= RST_FALL_LEVEL;
         drop_level_ff <= RST_DROP_LEVEL;
         pulse_low_ff  <= RST_PULSE_LOW;
         pulse_high_ff <= RST_PULSE_HIGH;
         oxygen_low_ff <= RST_OXYGEN_LOW;
         cooldown_ff   <= RST_COOLDOWN_TICKS;
         hold_ff       <= RST_HOLD_TICKS;
         period_ff     <= RST_AVERAGE_PERIOD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FALL_LEVEL:     fall_level_ff <= csr_wdata[15:0];
            CSR_DROP_LEVEL:     drop_level_ff <= csr_wdata[15:0];
            CSR_PULSE_LOW:      pulse_low_ff  <= csr_wdata[7:0];
            CSR_PULSE_HIGH:     pulse_high_ff <= csr_wdata[7:0];
            CSR_OXYGEN_LOW:     oxygen_low_ff <= csr_wdata[6:0];
            CSR_COOLDOWN_TICKS: cooldown_ff   <= csr_wdata[TICK_REG_BITS-1:0];
            CSR_HOLD_TICKS:     hold_ff       <= csr_wdata[TICK_REG_BITS-1:0];
            CSR_AVERAGE_PERIOD: period_ff     <= csr_wdata[TICK_REG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // operand and arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         button_ff <= req_tdata[0];
         abs0_ff   <= axis_abs(req_tdata[16:1]);
         abs1_ff   <= axis_abs(req_tdata[32:17]);
         abs2_ff   <= axis_abs(req_tdata[48:33]);
         heart_ff  <= req_tdata[56:49];
         spo_ff    <= req_tdata[63:57];
         prod_ff   <= '0;
         acc_ff    <= '0;
         rem_ff    <= '0;
         root_ff   <= '0;
      end
      if (cmd.square) begin
         prod_ff <= SQ_BITS'(abs0_ff) * SQ_BITS'(abs0_ff);
         abs0_ff <= abs1_ff;
         abs1_ff <= abs2_ff;
         abs2_ff <= '0;
         acc_ff  <= acc_ff + prod_ff;
      end
      if (cmd.root_step) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         acc_ff  <= {acc_ff[SQ_BITS-3:0], 2'b00};
      end
      if (cmd.decide) begin
         raised_ff   <= raise_now;
         dropped_ff  <= drop_now;
         released_ff <= release_now;
         kind_ff     <= kind_now;
      end
      if (cmd.mean_mul) begin
         mprod_ff <= MPROD_BITS'(sum_ff * RECIP_BITS'(RECIP_VALUE));
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {1'b0, mean_ff, root_ff, released_ff, dropped_ff, kind_ff,
                         raised_ff, (alert_ff != ALERT_NIL)};
      end
   end

   // monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         sum_ff         <= '0;
         pos_ff         <= '0;
         mean_ff        <= '0;
         alert_ff       <= ALERT_NIL;
         t_alarm_ff     <= '0;
         t_alert_ff     <= '0;
         t_avg_ff       <= '0;
         avg_pending_ff <= 1'b0;
      end else begin
         if (cmd.decide) begin
            alert_ff       <= alert_new;
            t_alarm_ff     <= raise_now ? '0 : t_alarm_inc;
            t_alert_ff     <= raise_now ? '0 : t_alert_inc;
            t_avg_ff       <= avg_now ? '0 : t_avg_inc;
            avg_pending_ff <= avg_now;
            if (raise_now) begin
               for (int i = 0; i < RING_DEPTH; i++) begin
                  ring_ff[i] <= '0;
               end
               sum_ff <= '0;
            end else if (avg_now) begin
               ring_ff[pos_ff] <= root_ff;
               sum_ff          <= sum_upd;
               pos_ff          <= (pos_ff == RING_IDX_BITS'(RING_DEPTH - 1)) ?
                                  '0 : pos_ff + 1'b1;
            end
         end
         if (cmd.mean_div) begin
            mean_ff <= mprod_ff[RECIP_SHIFT +: MAG_BITS];
         end
      end
   end

   assign status.avg_pending = avg_pending_ff;
   assign rsp_tdata          = rsp_data_ff;

endmodule

### hw/rtl/fall_and_vitals_alert_monitor.sv
// top level of the fall and vitals alert monitor
// depends on fva_pkg, fva_ctrl, fva_dpath and the assertion macro header
//
//   group  direction  ports                            carries
//   req    in         req_tvalid/tready/tdata[63:0]    one sensor tick
//   rsp    out        rsp_tvalid/tready/tdata[39:0]    one status result per tick
//   csr    in         csr_we/index[2:0]/wdata[23:0]    threshold and timer writes
//
// rsp_tvalid rises after acceptance once the sequencer has squared the axes on the shared
// multiplier, run sixteen root steps, made the decision, done the reciprocal multiply plus
// the mean store when the ring is updated, and loaded the result
// synchronous reset clears the ring, sums, timers and alarm at once; no clearing pass
// req_tready is high only while the sequencer idles; a waiting result does not block it
// a stalled rsp side holds the finished result and the sequencer waits before reload
`include "fall_and_vitals_alert_monitor_assert.svh"

module fall_and_vitals_alert_monitor
   import fva_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [0] button_pressed, [16:1] accel_x, [32:17] accel_y, [48:33] accel_z,
   // [56:49] heart_rate, [63:57] oxygen_saturation
   input  logic [REQ_DATA_BITS-1:0]   req_tdata,
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [0] alarm_on, [1] alert_raised, [4:2] alert_kind, [5] alert_dropped,
   // [6] alarm_released, [22:7] current_magnitude, [38:23] mean_magnitude,
   // [39] zero
   output logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   // configuration write port
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   // command and status between the sequencer and the datapath
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: accepts one request, steps the datapath, presents the result
   fva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // datapath: magnitude, alert decision, ring mean and result register
   fva_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

   // one request in flight: no second acceptance right after one
   `FVA_ASSERT_NEXT(a_single_request, clock, reset, req_tvalid && req_tready, !req_tready)
   // the sequencer never issues two datapath commands at once
   `FVA_ASSERT_NOW(a_cmd_exclusive, clock, reset, 1'b1, $onehot0(dp_cmd))
   // a result load is always presented on the rsp side next cycle
   `FVA_ASSERT_NEXT(a_result_shown, clock, reset, dp_cmd.out_load, rsp_tvalid)

endmodule
